// ----- rtl/vgsd_pkg.sv -----
package vgsd_pkg;

    localparam int SUM_WIDTH = 16;
    localparam int STROKE_W  = 8;
    localparam int ORIGIN_W  = 16;
    localparam int COORD_W   = 32;
    localparam int SCALE_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = CFG_IDX_W'(1);

    localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(1);
    localparam logic [STROKE_W-1:0] MOVE_MARK   = {1'b1, {(STROKE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        PK_MOVE = 2'd0,
        PK_LINE = 2'd1,
        PK_NONE = 2'd2
    } t_point_kind;

endpackage

// ----- rtl/vgsd_in_if.sv -----
interface vgsd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [vgsd_pkg::STROKE_W-1:0]  stroke_byte;
    logic                                  first_byte;
    logic                                  last_byte;
    logic signed [vgsd_pkg::ORIGIN_W-1:0]  origin_x;
    logic signed [vgsd_pkg::ORIGIN_W-1:0]  origin_y;

    modport source (
        output valid, stroke_byte, first_byte, last_byte, origin_x, origin_y,
        input  ready
    );
    modport sink (
        input  valid, stroke_byte, first_byte, last_byte, origin_x, origin_y,
        output ready
    );
endinterface

// ----- rtl/vgsd_out_if.sv -----
interface vgsd_out_if;
    logic                                 valid;
    logic                                 ready;
    vgsd_pkg::t_point_kind                point_kind;
    logic signed [vgsd_pkg::COORD_W-1:0]  point_x;
    logic signed [vgsd_pkg::COORD_W-1:0]  point_y;
    logic                                 glyph_end;

    modport source (
        output valid, point_kind, point_x, point_y, glyph_end,
        input  ready
    );
    modport sink (
        input  valid, point_kind, point_x, point_y, glyph_end,
        output ready
    );
endinterface

// ----- rtl/vector_glyph_stroke_decoder.sv -----
// A word that completes a point or ends the glyph gives a result word via the
// input register, then the result register.
// Throughput: one word per cycle unless the output stalls; the decode, 32x8
// scale multiply and origin add form the single stage between the registers.
// Reset (synchronous, active low): scales to 1, glyph idle until a first byte.
module vector_glyph_stroke_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vgsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vgsd_pkg::SCALE_W-1:0]     i_cfg_data,
    vgsd_in_if.sink                          i_in,
    vgsd_out_if.source                       o_out
);

    // input register
    logic                                  r_s1_valid;
    logic [vgsd_pkg::STROKE_W-1:0]         r_s1_byte;
    logic                                  r_s1_first;
    logic                                  r_s1_last;
    logic [vgsd_pkg::ORIGIN_W-1:0]         r_s1_org_x;
    logic [vgsd_pkg::ORIGIN_W-1:0]         r_s1_org_y;

    // configuration
    logic [vgsd_pkg::SCALE_W-1:0]          r_scale_x;
    logic [vgsd_pkg::SCALE_W-1:0]          r_scale_y;

    // decoder state
    logic                                  r_pair_phase, n_pair_phase;
    logic                                  r_move_flag,  n_move_flag;
    logic [vgsd_pkg::STROKE_W-1:0]         r_held,       n_held;
    logic [vgsd_pkg::SUM_WIDTH-1:0]        r_sum_x,      n_sum_x;
    logic [vgsd_pkg::SUM_WIDTH-1:0]        r_sum_y,      n_sum_y;
    logic                                  r_zero_wait,  n_zero_wait;
    logic                                  r_wait_move,  n_wait_move;
    logic                                  r_done,       n_done;
    logic [vgsd_pkg::ORIGIN_W-1:0]         r_lat_x,      n_lat_x;
    logic [vgsd_pkg::ORIGIN_W-1:0]         r_lat_y,      n_lat_y;

    // result register
    logic                                  r_out_valid;
    vgsd_pkg::t_point_kind                 r_out_kind,   n_kind;
    logic [vgsd_pkg::COORD_W-1:0]          r_out_x,      n_x;
    logic [vgsd_pkg::COORD_W-1:0]          r_out_y,      n_y;
    logic                                  r_out_end;

    logic                                  n_have;
    logic                                  out_free;
    logic                                  s1_fire;
    logic                                  in_fire;
    logic                                  s1_emit;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_fire  = r_s1_valid && out_free;
    assign in_fire  = i_in.valid && i_in.ready;
    assign s1_emit  = s1_fire && (n_have || r_s1_last);

    assign i_in.ready = !r_s1_valid || out_free;

    assign o_out.valid      = r_out_valid;
    assign o_out.point_kind = r_out_kind;
    assign o_out.point_x    = r_out_x;
    assign o_out.point_y    = r_out_y;
    assign o_out.glyph_end  = r_out_end;

    always_comb begin
        logic [vgsd_pkg::COORD_W-1:0] sx;
        logic [vgsd_pkg::COORD_W-1:0] sy;
        logic [vgsd_pkg::COORD_W-1:0] ox;
        logic [vgsd_pkg::COORD_W-1:0] oy;
        logic                         b_zero;
        logic                         b_mark;

        n_pair_phase = r_pair_phase;
        n_move_flag  = r_move_flag;
        n_held       = r_held;
        n_sum_x      = r_sum_x;
        n_sum_y      = r_sum_y;
        n_zero_wait  = r_zero_wait;
        n_wait_move  = r_wait_move;
        n_done       = r_done;
        n_lat_x      = r_lat_x;
        n_lat_y      = r_lat_y;
        n_have       = 1'b0;
        n_kind       = vgsd_pkg::PK_NONE;
        b_zero       = (r_s1_byte == '0);
        b_mark       = (r_s1_byte == vgsd_pkg::MOVE_MARK);

        if (r_s1_first) begin
            n_lat_x      = r_s1_org_x;
            n_lat_y      = r_s1_org_y;
            n_sum_x      = '0;
            n_sum_y      = '0;
            n_pair_phase = 1'b0;
            n_move_flag  = 1'b0;
            n_held       = '0;
            n_zero_wait  = 1'b0;
            n_wait_move  = 1'b0;
            n_done       = 1'b0;
        end

        if (!n_done) begin
            if (n_zero_wait) begin
                n_zero_wait = 1'b0;
                if (b_zero) begin
                    n_done = 1'b1;
                end else begin
                    n_have = 1'b1;
                    n_kind = n_wait_move ? vgsd_pkg::PK_MOVE : vgsd_pkg::PK_LINE;
                    if (b_mark) begin
                        n_move_flag = 1'b1;
                    end else begin
                        n_held       = r_s1_byte;
                        n_pair_phase = 1'b1;
                    end
                end
            end else if (!n_pair_phase) begin
                if (b_mark && !n_move_flag) begin
                    n_move_flag = 1'b1;
                end else begin
                    n_held       = r_s1_byte;
                    n_pair_phase = 1'b1;
                end
            end else begin
                n_pair_phase = 1'b0;
                if (n_held == '0 && b_zero && !r_s1_last) begin
                    n_zero_wait = 1'b1;
                    n_wait_move = n_move_flag;
                end else begin
                    n_sum_x = n_sum_x + vgsd_pkg::SUM_WIDTH'($signed(n_held));
                    n_sum_y = n_sum_y + vgsd_pkg::SUM_WIDTH'($signed(r_s1_byte));
                    n_have  = 1'b1;
                    n_kind  = n_move_flag ? vgsd_pkg::PK_MOVE : vgsd_pkg::PK_LINE;
                end
                n_move_flag = 1'b0;
            end
        end

        // point = origin + sign-extended sum * scale, modulo 2^32
        sx = vgsd_pkg::COORD_W'($signed(n_sum_x));
        sy = vgsd_pkg::COORD_W'($signed(n_sum_y));
        ox = vgsd_pkg::COORD_W'($signed(n_lat_x));
        oy = vgsd_pkg::COORD_W'($signed(n_lat_y));
        n_x = '0;
        n_y = '0;
        if (n_have) begin
            n_x = ox + vgsd_pkg::COORD_W'(sx * vgsd_pkg::COORD_W'(r_scale_x));
            n_y = oy + vgsd_pkg::COORD_W'(sy * vgsd_pkg::COORD_W'(r_scale_y));
        end

        if (r_s1_last) begin
            n_done       = 1'b1;
            n_zero_wait  = 1'b0;
            n_wait_move  = 1'b0;
            n_pair_phase = 1'b0;
            n_move_flag  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_scale_x    <= vgsd_pkg::SCALE_RESET;
            r_scale_y    <= vgsd_pkg::SCALE_RESET;
            r_pair_phase <= 1'b0;
            r_move_flag  <= 1'b0;
            r_held       <= '0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_zero_wait  <= 1'b0;
            r_wait_move  <= 1'b0;
            r_done       <= 1'b1;
            r_lat_x      <= '0;
            r_lat_y      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == vgsd_pkg::REG_SCALE_X) begin
                    r_scale_x <= i_cfg_data;
                end else if (i_cfg_idx == vgsd_pkg::REG_SCALE_Y) begin
                    r_scale_y <= i_cfg_data;
                end
            end

            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_pair_phase <= n_pair_phase;
                r_move_flag  <= n_move_flag;
                r_held       <= n_held;
                r_sum_x      <= n_sum_x;
                r_sum_y      <= n_sum_y;
                r_zero_wait  <= n_zero_wait;
                r_wait_move  <= n_wait_move;
                r_done       <= n_done;
                r_lat_x      <= n_lat_x;
                r_lat_y      <= n_lat_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte  <= i_in.stroke_byte;
            r_s1_first <= i_in.first_byte;
            r_s1_last  <= i_in.last_byte;
            r_s1_org_x <= i_in.origin_x;
            r_s1_org_y <= i_in.origin_y;
        end
        if (s1_emit) begin
            r_out_kind <= n_kind;
            r_out_x    <= n_x;
            r_out_y    <= n_y;
            r_out_end  <= r_s1_last;
        end
    end

    a_none_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == vgsd_pkg::PK_NONE |-> r_out_end)
        else $error("no-point word without glyph end");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == vgsd_pkg::PK_NONE |-> r_out_x == '0 && r_out_y == '0)
        else $error("no-point word with non-zero coordinates");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_pair_phase && !r_zero_wait && !r_move_flag)
        else $error("ended glyph left with pending stroke state");

    a_wait_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero_wait |-> !r_pair_phase && !r_move_flag)
        else $error("held zero pair with open point");

    a_free_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty result register");

endmodule
